/* rtl/core/ddss_pkg.sv */
// Shared types, command codes and the glyph-to-segment table for the display scanner.
package ddss_pkg;

    // Command codes carried in the input tuser
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_INT   = 3'd1;
    localparam logic [2:0] CMD_HUND  = 3'd2;
    localparam logic [2:0] CMD_DASH  = 3'd3;
    localparam logic [2:0] CMD_MODE  = 3'd4;

    // Mode text codes
    localparam logic [1:0] MODE_TXT_AUT = 2'd0;
    localparam logic [1:0] MODE_TXT_ON  = 2'd1;
    localparam logic [1:0] MODE_TXT_OFF = 2'd2;

    // Glyph codes
    localparam logic [4:0] GLYPH_BLANK = 5'd10;
    localparam logic [4:0] GLYPH_DASH  = 5'd11;
    localparam logic [4:0] GLYPH_T     = 5'd12;
    localparam logic [4:0] GLYPH_A     = 5'd13;
    localparam logic [4:0] GLYPH_N     = 5'd14;
    localparam logic [4:0] GLYPH_O     = 5'd15;
    localparam logic [4:0] GLYPH_F     = 5'd16;
    localparam logic [4:0] GLYPH_U     = 5'd17;

    localparam int          NUM_POS     = 6;
    localparam logic [5:0]  SELECT_NONE = 6'h3F;
    localparam logic [7:0]  POINT_BIT   = 8'h80;

    typedef logic [4:0] t_glyph;

    // Glyph load request for one three-digit display
    typedef struct packed {
        logic   load;      // write the three glyphs
        logic   pt_write;  // update the point flag
        logic   pt_value;
        t_glyph ones;
        t_glyph tens;
        t_glyph hund;
    } t_load;

    // Segment pattern per glyph, bits 0..6 = a..g
    function automatic logic [7:0] seg_lut(input t_glyph g);
        logic [7:0] s;
        case (g)
            5'd0:  s = 8'h3F;
            5'd1:  s = 8'h06;
            5'd2:  s = 8'h5B;
            5'd3:  s = 8'h4F;
            5'd4:  s = 8'h66;
            5'd5:  s = 8'h6D;
            5'd6:  s = 8'h7D;
            5'd7:  s = 8'h07;
            5'd8:  s = 8'h7F;
            5'd9:  s = 8'h6F;
            5'd11: s = 8'h40;
            5'd12: s = 8'h78;
            5'd13: s = 8'h77;
            5'd14: s = 8'h54;
            5'd15: s = 8'h5C;
            5'd16: s = 8'h71;
            5'd17: s = 8'h1C;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/ddss_glyph_enc.sv */
// Command decode: turns a set command into the three glyphs and point flag for one display.
module ddss_glyph_enc (
    input  logic [2:0]           i_command,
    input  logic signed [10:0]   i_value,
    input  logic [1:0]           i_mode_code,
    output ddss_pkg::t_load      o_load
);
    import ddss_pkg::*;

    logic        w_blank_val;
    logic        w_neg;
    logic [9:0]  w_mag;
    logic [16:0] w_hprod;
    logic [3:0]  w_h;
    logic [6:0]  w_rem;
    logic [14:0] w_tprod;
    logic [3:0]  w_t;
    logic [3:0]  w_o;

    assign w_blank_val = (i_value == 11'sd1000);
    assign w_neg       = i_value[10];

    // Clamp to the displayable magnitude
    always_comb begin
        if (w_neg) begin
            if (i_command == CMD_INT && i_value >= -11'sd99) begin
                w_mag = 10'((-i_value));
            end else if (i_command == CMD_INT) begin
                w_mag = 10'd99;
            end else begin
                w_mag = 10'd0;
            end
        end else if (i_value > 11'sd999) begin
            w_mag = 10'd999;
        end else begin
            w_mag = i_value[9:0];
        end
    end

    // Digit split by reciprocal multiplies, exact for magnitudes up to 999
    assign w_hprod = 17'(w_mag) * 17'd41;
    assign w_h     = w_hprod[15:12];
    assign w_rem   = 7'(w_mag - 10'(w_h) * 10'd100);
    assign w_tprod = 15'(w_rem) * 15'd205;
    assign w_t     = w_tprod[14:11];
    assign w_o     = 4'(w_rem - 7'(w_t) * 7'd10);

    always_comb begin
        o_load          = '0;
        case (i_command)
            CMD_INT, CMD_HUND: begin
                o_load.load     = 1'b1;
                o_load.pt_write = 1'b1;
                o_load.pt_value = (i_command == CMD_HUND);
                if (w_blank_val) begin
                    o_load.ones = GLYPH_BLANK;
                    o_load.tens = GLYPH_BLANK;
                    o_load.hund = GLYPH_BLANK;
                end else begin
                    o_load.ones = t_glyph'(w_o);
                    o_load.tens = t_glyph'(w_t);
                    o_load.hund = (w_neg && i_command == CMD_INT) ? GLYPH_DASH
                                                                  : t_glyph'(w_h);
                end
            end
            CMD_DASH: begin
                o_load.load = 1'b1;
                o_load.ones = GLYPH_DASH;
                o_load.tens = GLYPH_DASH;
                o_load.hund = GLYPH_DASH;
            end
            CMD_MODE: begin
                case (i_mode_code)
                    MODE_TXT_AUT: begin
                        o_load.load = 1'b1;
                        o_load.ones = GLYPH_T;
                        o_load.tens = GLYPH_U;
                        o_load.hund = GLYPH_A;
                    end
                    MODE_TXT_ON: begin
                        o_load.load = 1'b1;
                        o_load.ones = GLYPH_N;
                        o_load.tens = GLYPH_O;
                        o_load.hund = GLYPH_BLANK;
                    end
                    MODE_TXT_OFF: begin
                        o_load.load = 1'b1;
                        o_load.ones = GLYPH_F;
                        o_load.tens = GLYPH_F;
                        o_load.hund = GLYPH_O;
                    end
                    default: o_load.load = 1'b0;
                endcase
            end
            default: o_load = '0;
        endcase
    end

endmodule

/* rtl/core/dual_display_seven_segment_scanner.sv */
// Top level: input register, glyph store, scan logic and output register.
//
// Two three-digit seven-segment displays on one six-digit multiplexed bus.
// Position p belongs to display p mod 2 (ones at d, tens at d+2, hundreds
// at d+4). Input words on the s_ channel carry a command in tuser; set
// commands load glyphs and produce no output word, a tick command scans one
// position and produces exactly one output word on the m_ channel with the
// segment pattern and the active-low digit select.
// Timing: an accepted word sits in the input register and is decoded in the
// following cycle; a tick result is registered onto o_m_tvalid. One word per
// cycle is accepted while the output side takes its words; the single result
// register and the input register set that rate. When the receiver stalls
// with a result pending, the input register holds its word and o_s_tready
// drops once it is full; nothing is lost. Reset (synchronous, active low)
// clears all glyphs to zero, the scan position, the point flags,
// display_enable and both valid flags. display_enable must be written
// through i_cfg_we / i_cfg_wdata while idle; the block does not enforce it.
// While it is 0 ticks return a dark word and the scan position holds.
module dual_display_seven_segment_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: display_enable
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [10:0] value, [12:11] mode_code, [15:13] zero
    input  logic [3:0]  i_s_tuser,   // [2:0] command, [3] display_select
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [7:0] segment_pattern, [13:8] digit_select_n
);
    import ddss_pkg::*;

    // Input register
    logic               r_in_valid;
    logic [2:0]         r_command;
    logic               r_dsel;
    logic signed [10:0] r_value;
    logic [1:0]         r_mode;

    // Block state
    logic               r_enable;
    t_glyph             r_glyph [NUM_POS];
    t_glyph             n_glyph [NUM_POS];
    logic [2:0]         r_scan;
    logic [2:0]         n_scan;
    logic [1:0]         r_point;
    logic [1:0]         n_point;

    // Output register
    logic               r_out_valid;
    logic [7:0]         r_seg;
    logic [5:0]         r_sel;

    logic               w_accept;
    logic               w_go;
    logic               w_tick;
    t_load              w_load;
    logic [2:0]         w_pos;
    t_glyph             w_g;
    logic [7:0]         w_seg;
    logic [5:0]         w_sel;

    assign w_go       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_go;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_tick     = (r_command == CMD_TICK);

    ddss_glyph_enc u_enc (
        .i_command   (r_command),
        .i_value     (r_value),
        .i_mode_code (r_mode),
        .o_load      (w_load)
    );

    // Scan one position
    always_comb begin
        w_pos = (r_scan > 3'd5) ? 3'd0 : r_scan;
        w_g   = r_glyph[w_pos];
        w_seg = 8'h00;
        w_sel = SELECT_NONE;
        n_scan = r_scan;
        if (r_enable) begin
            if (w_g != GLYPH_BLANK) begin
                w_seg = seg_lut(w_g);
                w_sel = SELECT_NONE & ~(6'd1 << w_pos);
                if (w_pos[2] && r_point[w_pos[0]]) begin
                    w_seg = w_seg | POINT_BIT;
                end
            end
            n_scan = (w_pos == 3'd5) ? 3'd0 : w_pos + 3'd1;
        end
    end

    // Glyph and point flag updates
    always_comb begin
        n_point = r_point;
        for (int i = 0; i < NUM_POS; i++) begin
            n_glyph[i] = r_glyph[i];
        end
        if (w_load.pt_write) begin
            n_point[r_dsel] = w_load.pt_value;
        end
        if (w_load.load) begin
            n_glyph[{2'd0, r_dsel}] = w_load.ones;
            n_glyph[{2'd1, r_dsel}] = w_load.tens;
            n_glyph[{2'd2, r_dsel}] = w_load.hund;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
        if (w_accept) begin
            r_command <= i_s_tuser[2:0];
            r_dsel    <= i_s_tuser[3];
            r_value   <= i_s_tdata[10:0];
            r_mode    <= i_s_tdata[12:11];
        end
    end

    // State and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_scan   <= '0;
            r_point  <= '0;
            for (int i = 0; i < NUM_POS; i++) begin
                r_glyph[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (w_go) begin
                if (w_tick) begin
                    r_scan <= n_scan;
                end
                r_point <= n_point;
                for (int i = 0; i < NUM_POS; i++) begin
                    r_glyph[i] <= n_glyph[i];
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_go && w_tick) begin
            r_seg <= w_seg;
            r_sel <= w_sel;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_sel, r_seg};

endmodule

/* rtl/core/ddss_checker.sv */
// Port-level checker for the display scanner, bound to the top level.
module ddss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);
    import ddss_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // At most one digit is driven
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($onehot(~o_m_tdata[13:8]) || o_m_tdata[13:8] == SELECT_NONE))
        else $error("more than one digit selected");

    // A dark position carries no segments
    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[13:8] == SELECT_NONE |-> o_m_tdata[7:0] == 8'h00)
        else $error("segments lit with no digit selected");

    // Decimal point only on a hundreds digit
    a_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[7] |-> o_m_tdata[13:12] != 2'b11)
        else $error("decimal point outside the hundreds digits");

    // No result word right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind dual_display_seven_segment_scanner ddss_checker u_ddss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
